// ----- rtl/core/mrsrb_pkg.sv -----
// Shared types and constants for the sectioned ring buffer.
package mrsrb_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_REC_READY = 3'd1,
    CMD_CMP_READY = 3'd2,
    CMD_ACK       = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SEC_COUNT = 3'd0,
    REG_SEC_SIZE  = 3'd1,
    REG_RCV_COUNT = 3'd2,
    REG_OP_ENABLE = 3'd3,
    REG_THR_NORM  = 3'd4,
    REG_THR_WARN  = 3'd5,
    REG_THR_DANG  = 3'd6
  } reg_e;

  localparam logic [1:0] OP_IDLE    = 2'd0;
  localparam logic [1:0] OP_NORMAL  = 2'd1;
  localparam logic [1:0] OP_WARNING = 2'd2;
  localparam logic [1:0] OP_DANGER  = 2'd3;

  localparam logic [11:0] SIZE_LIMIT = 12'd2048;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [27:0] sum_t;

endpackage

// ----- rtl/core/mrsrb_ram.sv -----
// Generic single-port RAM with registered read data.
module mrsrb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mrsrb_addr.sv -----
// Sample address unit: section times size plus position, reduced modulo the memory depth.
module mrsrb_addr #(
  parameter int unsigned MEM_DEPTH    = 4096,
  parameter int unsigned MAX_SECTIONS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(MAX_SECTIONS)-1:0]  sec_i,
  input  logic [11:0]                      size_i,
  input  logic [11:0]                      pos_i,
  output logic                             done_o,
  output logic [$clog2(MEM_DEPTH)-1:0]     addr_o
);

  localparam int unsigned SEC_W     = $clog2(MAX_SECTIONS);
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned SUM_W     = SEC_W + 11;
  localparam int unsigned LG        = $clog2(MEM_DEPTH + 1) - 1;
  localparam int unsigned RED_STEPS = (SUM_W > LG) ? SUM_W - LG : 1;
  localparam int unsigned CW        = $clog2(RED_STEPS + 1);
  localparam int unsigned RW        = SUM_W + 17;

  logic [SUM_W-1:0] a_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q;
  logic             done_q;
  logic [RW-1:0]    sub_val;

  // One conditional subtract of a shifted depth per cycle, largest first.
  assign sub_val = RW'(MEM_DEPTH) << cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(RED_STEPS - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= SUM_W'(RW'(sec_i) * RW'(size_i) + RW'(pos_i));
    end else if (run_q && (RW'(a_q) >= sub_val)) begin
      a_q <= SUM_W'(RW'(a_q) - sub_val);
    end
  end

  assign done_o = done_q;
  assign addr_o = AW'(a_q);

endmodule

// ----- rtl/core/mrsrb_cls.sv -----
// Section mean classifier: for each threshold, danger first, a registered product step and then a compare step.
module mrsrb_cls (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             enable_i,
  input  mrsrb_pkg::sum_t    sum_i,
  input  logic [11:0]      size_i,
  input  mrsrb_pkg::sample_t thr_normal_i,
  input  mrsrb_pkg::sample_t thr_warning_i,
  input  mrsrb_pkg::sample_t thr_danger_i,
  output logic             done_o,
  output logic [1:0]       state_o
);
  import mrsrb_pkg::*;

  logic               run_q;
  logic               done_q;
  logic               phase_q;
  logic [1:0]         sel_q;
  logic [1:0]         state_q;
  sum_t               sum_q;
  logic signed [28:0] prod_q;
  logic signed [28:0] prod_d;
  sample_t            thr_sel;
  logic               gt;

  always_comb begin
    case (sel_q)
      OP_DANGER:  thr_sel = thr_danger_i;
      OP_WARNING: thr_sel = thr_warning_i;
      default:    thr_sel = thr_normal_i;
    endcase
  end

  // The mean compare is done as sum > threshold * size, which is exact.
  assign prod_d = $signed(29'(thr_sel)) * $signed(29'({1'b0, size_i}));
  assign gt     = $signed(29'(sum_q)) > prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      sel_q   <= OP_DANGER;
      state_q <= OP_IDLE;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sel_q   <= OP_DANGER;
        phase_q <= 1'b0;
        if (enable_i) begin
          run_q <= 1'b1;
        end else begin
          state_q <= OP_IDLE;
          done_q  <= 1'b1;
        end
      end else if (run_q) begin
        if (!phase_q) begin
          phase_q <= 1'b1;
        end else if (gt) begin
          state_q <= sel_q;
          run_q   <= 1'b0;
          done_q  <= 1'b1;
        end else if (sel_q == OP_NORMAL) begin
          state_q <= OP_IDLE;
          run_q   <= 1'b0;
          done_q  <= 1'b1;
        end else begin
          sel_q   <= sel_q - 1'b1;
          phase_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_i;
    end
    if (run_q && !phase_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o  = done_q;
  assign state_o = state_q;

endmodule

// ----- rtl/core/multi_reader_section_ring_buffer_top.sv -----
// Top level of the sectioned sample ring with one writer and several readers.
//
//   Channel   Ports                                         Handshake
//   --------  --------------------------------------------  --------------------------
//   request   command_i sample_i receiver_i count_i         taken when start && !busy
//             offset_i
//   result    ready_res_o read_data_o op_state_o            one cycle, out_valid_o
//             section_published_o
//   config    psel penable pwrite paddr pwdata prdata        APB, pready always high
//
// One request is worked on at a time. A write passes the normalise and address states,
// where the address unit runs RED_STEPS reduction steps (RED_STEPS = section width +
// 11 - floor(log2 MEM_DEPTH), at least 1, so 2 at the defaults), then the classifier
// state when it publishes. A read adds a wait state for the memory port. Ready queries
// and acknowledges step through count sections, stopping early when a query fails.
// The result strobe rises in the same cycle as busy falls. A stored section index
// beyond the section count is reduced first. Reset clears all control state; the
// sample memory holds no reset value. The receiver cannot stall results.
module multi_reader_section_ring_buffer_top #(
  parameter int unsigned MEM_DEPTH    = 4096,
  parameter int unsigned MAX_SECTIONS = 8,
  parameter int unsigned MAX_READERS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic signed [15:0] sample_i,
  input  logic [1:0]  receiver_i,
  input  logic [3:0]  count_i,
  input  logic [10:0] offset_i,
  output logic        out_valid_o,
  output logic        ready_res_o,
  output logic signed [15:0] read_data_o,
  output logic [1:0]  op_state_o,
  output logic        section_published_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrsrb_pkg::*;

  localparam int unsigned SEC_W = $clog2(MAX_SECTIONS);
  localparam int unsigned SC_W  = $clog2(MAX_SECTIONS + 1);
  localparam int unsigned RD_W  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int unsigned AW    = $clog2(MEM_DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_NORM   = 7'b0000010,
    ST_ADDR   = 7'b0000100,
    ST_RWAIT  = 7'b0001000,
    ST_CLASS  = 7'b0010000,
    ST_LOOP   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } fsm_e;

  // Configuration registers.
  logic [3:0]  sec_count_q;
  logic [11:0] sec_size_q;
  logic [2:0]  rcv_count_q;
  logic        op_en_q;
  sample_t     thr_norm_q, thr_warn_q, thr_dang_q;

  fsm_e        st_q;
  logic [2:0]  cmd_q;
  sample_t     sample_q;
  logic [1:0]  receiver_q;
  logic [3:0]  cnt_q;
  logic [10:0] offset_q;
  logic [SEC_W-1:0] idx_q, k_q;
  logic [3:0]  c_q;
  logic        ok_q;

  logic [11:0]      fill_q;
  logic [SEC_W-1:0] rec_sec_q;
  logic [SEC_W-1:0] rd_sec_q [MAX_READERS];
  logic [MAX_SECTIONS-1:0] pub_q;
  logic [MAX_READERS-1:0]  ack_q [MAX_SECTIONS];
  sum_t        sum_q;
  logic [1:0]  cur_state_q;

  logic        out_valid_q, out_ready_q, out_pub_q, pub_evt_q;
  logic [15:0] rdata_q;
  logic [1:0]  out_op_q;

  logic [SC_W-1:0]        sc_eff;
  logic [11:0]            ss_eff;
  logic [MAX_READERS-1:0] rmask;
  logic                   no_readers;
  logic                   r_ok_in;
  logic [RD_W-1:0]        r_idx_in, r_idx;
  logic [MAX_READERS-1:0] r_bit;
  logic [MAX_READERS-1:0] ack_new;
  logic [SEC_W-1:0]       k_next;
  logic [SEC_W-1:0]       idx_next;
  sum_t                   sum_new;
  logic                   accept;
  logic                   cfg_we;

  logic             addr_start, addr_done;
  logic [11:0]      addr_pos;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [15:0]      mem_rdata;
  logic             cls_start, cls_done;
  logic [1:0]       cls_state;

  // Effective register values after clamping.
  always_comb begin
    if (sec_count_q == 4'd0) begin
      sc_eff = SC_W'(1);
    end else if (32'(sec_count_q) > MAX_SECTIONS) begin
      sc_eff = SC_W'(MAX_SECTIONS);
    end else begin
      sc_eff = SC_W'(sec_count_q);
    end
    if (sec_size_q == 12'd0) begin
      ss_eff = 12'd1;
    end else if (sec_size_q > SIZE_LIMIT) begin
      ss_eff = SIZE_LIMIT;
    end else begin
      ss_eff = sec_size_q;
    end
    for (int i = 0; i < MAX_READERS; i++) begin
      rmask[i] = 32'(rcv_count_q) > i;
    end
  end

  assign no_readers = (rcv_count_q == 3'd0);
  assign r_ok_in    = 32'(receiver_i) < MAX_READERS;
  assign r_idx_in   = RD_W'(receiver_i);
  assign r_idx      = RD_W'(receiver_q);
  assign r_bit      = MAX_READERS'(1) << r_idx;
  assign ack_new    = ack_q[k_q] | r_bit;
  assign k_next     = (SC_W'(k_q) + SC_W'(1) == sc_eff) ? '0 : SEC_W'(k_q + 1'b1);
  assign idx_next   = (SC_W'(idx_q) + SC_W'(1) == sc_eff) ? '0 : SEC_W'(idx_q + 1'b1);
  assign sum_new    = sum_q + 28'(sample_q);
  assign accept     = start && (st_q == ST_IDLE);

  assign addr_start = (st_q == ST_NORM) && (SC_W'(idx_q) < sc_eff) &&
                      ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ));
  assign addr_pos   = (cmd_q == CMD_WRITE) ? fill_q : {1'b0, offset_q};
  assign mem_we     = (st_q == ST_ADDR) && addr_done && (cmd_q == CMD_WRITE);
  assign cls_start  = mem_we && (13'(fill_q) + 13'd1 >= 13'(ss_eff));

  mrsrb_addr #(
    .MEM_DEPTH   (MEM_DEPTH),
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(addr_start),
    .sec_i  (idx_q),
    .size_i (ss_eff),
    .pos_i  (addr_pos),
    .done_o (addr_done),
    .addr_o (mem_addr)
  );

  mrsrb_ram #(
    .WIDTH(16),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(sample_q),
    .rdata_o(mem_rdata)
  );

  mrsrb_cls u_cls (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cls_start),
    .enable_i     (op_en_q),
    .sum_i        (sum_new),
    .size_i       (ss_eff),
    .thr_normal_i (thr_norm_q),
    .thr_warning_i(thr_warn_q),
    .thr_danger_i (thr_dang_q),
    .done_o       (cls_done),
    .state_o      (cls_state)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_SEC_COUNT: prdata = 32'(sec_count_q);
      REG_SEC_SIZE:  prdata = 32'(sec_size_q);
      REG_RCV_COUNT: prdata = 32'(rcv_count_q);
      REG_OP_ENABLE: prdata = 32'(op_en_q);
      REG_THR_NORM:  prdata = 32'(unsigned'(thr_norm_q));
      REG_THR_WARN:  prdata = 32'(unsigned'(thr_warn_q));
      REG_THR_DANG:  prdata = 32'(unsigned'(thr_dang_q));
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_count_q <= 4'd2;
      sec_size_q  <= 12'd128;
      rcv_count_q <= 3'd0;
      op_en_q     <= 1'b0;
      thr_norm_q  <= '0;
      thr_warn_q  <= '0;
      thr_dang_q  <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SEC_COUNT: sec_count_q <= pwdata[3:0];
        REG_SEC_SIZE:  sec_size_q  <= pwdata[11:0];
        REG_RCV_COUNT: rcv_count_q <= pwdata[2:0];
        REG_OP_ENABLE: op_en_q     <= pwdata[0];
        REG_THR_NORM:  thr_norm_q  <= pwdata[15:0];
        REG_THR_WARN:  thr_warn_q  <= pwdata[15:0];
        REG_THR_DANG:  thr_dang_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Request latch; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= command_i;
      sample_q   <= sample_i;
      receiver_q <= receiver_i;
      cnt_q      <= count_i;
      offset_q   <= offset_i;
    end
  end

  // Sequencer and ring state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      c_q         <= '0;
      ok_q        <= 1'b0;
      fill_q      <= '0;
      rec_sec_q   <= '0;
      pub_q       <= '0;
      sum_q       <= '0;
      cur_state_q <= OP_IDLE;
      pub_evt_q   <= 1'b0;
      rdata_q     <= '0;
      out_valid_q <= 1'b0;
      out_ready_q <= 1'b0;
      out_pub_q   <= 1'b0;
      out_op_q    <= OP_IDLE;
      for (int i = 0; i < MAX_READERS; i++) begin
        rd_sec_q[i] <= '0;
      end
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        ack_q[i] <= '1;
      end
    end else begin
      out_valid_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            pub_evt_q <= 1'b0;
            rdata_q   <= '0;
            ok_q      <= 1'b1;
            c_q       <= '0;
            st_q      <= ST_NORM;
            case (command_i)
              CMD_WRITE, CMD_REC_READY: idx_q <= rec_sec_q;
              CMD_CMP_READY, CMD_ACK, CMD_READ: begin
                if (r_ok_in) begin
                  idx_q <= rd_sec_q[r_idx_in];
                end else begin
                  ok_q <= 1'b0;
                  st_q <= ST_FINISH;
                end
              end
              default: begin
                ok_q <= 1'b0;
                st_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_NORM: begin
          // A stored index may exceed a smaller section count; reduce it first.
          if (SC_W'(idx_q) >= sc_eff) begin
            idx_q <= SEC_W'(SC_W'(idx_q) - sc_eff);
          end else begin
            k_q <= idx_q;
            if ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)) begin
              st_q <= ST_ADDR;
            end else begin
              st_q <= ST_LOOP;
            end
          end
        end
        ST_ADDR: begin
          if (addr_done) begin
            if (cmd_q == CMD_READ) begin
              st_q <= ST_RWAIT;
            end else if (cls_start) begin
              pub_q[idx_q] <= 1'b1;
              ack_q[idx_q] <= ack_q[idx_q] & ~rmask;
              rec_sec_q    <= idx_next;
              fill_q       <= '0;
              sum_q        <= '0;
              pub_evt_q    <= 1'b1;
              st_q         <= ST_CLASS;
            end else begin
              fill_q <= fill_q + 12'd1;
              sum_q  <= sum_new;
              st_q   <= ST_FINISH;
            end
          end
        end
        ST_RWAIT: begin
          rdata_q <= mem_rdata;
          st_q    <= ST_FINISH;
        end
        ST_CLASS: begin
          if (cls_done) begin
            cur_state_q <= cls_state;
            st_q        <= ST_FINISH;
          end
        end
        ST_LOOP: begin
          if ((c_q == cnt_q) || !ok_q) begin
            if (cmd_q == CMD_ACK) begin
              rd_sec_q[r_idx] <= k_q;
            end
            st_q <= ST_FINISH;
          end else begin
            c_q <= c_q + 4'd1;
            k_q <= k_next;
            case (cmd_q)
              CMD_REC_READY: begin
                if (no_readers) begin
                  pub_q[k_q] <= 1'b0;
                end else if (pub_q[k_q] || ((ack_q[k_q] & rmask) != rmask)) begin
                  ok_q <= 1'b0;
                end
              end
              CMD_CMP_READY: begin
                if (!pub_q[k_q] || ((ack_q[k_q] & r_bit) != '0)) begin
                  ok_q <= 1'b0;
                end
              end
              CMD_ACK: begin
                ack_q[k_q] <= ack_new;
                if ((ack_new & rmask) == rmask) begin
                  pub_q[k_q] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FINISH: begin
          out_valid_q <= 1'b1;
          out_ready_q <= ok_q &&
                         ((cmd_q == CMD_REC_READY) || (cmd_q == CMD_CMP_READY));
          out_pub_q   <= pub_evt_q;
          out_op_q    <= cur_state_q;
          st_q        <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign busy                = (st_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign ready_res_o         = out_ready_q;
  assign read_data_o         = rdata_q;
  assign op_state_o          = out_op_q;
  assign section_published_o = out_pub_q;

  // A result strobe never repeats back to back, since each request ends in one finish step.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe held for two cycles");

  // Only a write can publish a section.
  a_pub_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && section_published_o) |-> (cmd_q == CMD_WRITE))
    else $error("publish flag on a request that is not a write");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // A memory write happens only with a write request in progress.
  a_mem_write_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (busy && (cmd_q == CMD_WRITE)))
    else $error("memory written outside a write request");

endmodule
